### hw/rtl/hysteresis_period_meter_assert.svh
// ----------------------------------------------------------------------------
// hysteresis_period_meter_assert.svh
// Assertion macros shared by the period meter checker.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_PERIOD_METER_ASSERT_SVH
`define HYSTERESIS_PERIOD_METER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HPM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HPM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hpm_pkg.sv
// ----------------------------------------------------------------------------
// hpm_pkg
// Widths, register indexes, reset values and shared types of the period meter.
// ----------------------------------------------------------------------------
`default_nettype none

package hpm_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned THR_W    = 10;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned SUM_W    = 35;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned AVG_W    = 40;
  localparam int unsigned FREQ_W   = 35;
  localparam int unsigned FRAC_W   = 8;
  // Dividend of the average: period sum with eight fraction bits appended
  localparam int unsigned AVG_NUM_W = SUM_W + FRAC_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_SCALE = 2'd2;

  localparam logic [THR_W-1:0]   HIGH_THR_RST   = 10'd675;
  localparam logic [THR_W-1:0]   LOW_THR_RST    = 10'd552;
  localparam logic [SCALE_W-1:0] FREQ_SCALE_RST = 24'd100000;

  // Comparator / accumulator outcome for the beat on the input
  typedef struct packed {
    logic             level;
    logic             rise;
    logic             report;
    logic             zero;
    logic [SUM_W-1:0] sum;
  } front_t;

endpackage

`default_nettype wire

### hw/rtl/hpm_if.sv
// ----------------------------------------------------------------------------
// hpm_if
// Valid/ready channels carrying sample beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpm_in_if;
  logic                         valid;
  logic                         ready;
  logic [hpm_pkg::SAMPLE_W-1:0] sample;
  logic [hpm_pkg::TS_W-1:0]     timestamp;

  modport source (output valid, output sample, output timestamp, input ready);
  modport sink   (input valid, input sample, input timestamp, output ready);
endinterface

interface hpm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       level;
  logic                       rising_edge;
  logic                       report_valid;
  logic [hpm_pkg::AVG_W-1:0]  avg_period_q8;
  logic [hpm_pkg::FREQ_W-1:0] frequency_q8;
  logic                       zero_period;

  modport source (output valid, output level, output rising_edge, output report_valid,
                  output avg_period_q8, output frequency_q8, output zero_period,
                  input ready);
  modport sink   (input valid, input level, input rising_edge, input report_valid,
                  input avg_period_q8, input frequency_q8, input zero_period,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/hysteresis_period_meter.sv
// ----------------------------------------------------------------------------
// hysteresis_period_meter
// Schmitt-trigger period and frequency meter with bit-serial dividers.
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  ----------+-----+-------------------------------------------------------
//  in_i      | in  | sample, timestamp
//  out_o     | out | level, rising_edge, report_valid, avg_period_q8,
//            |     | frequency_q8, zero_period
//  cfg_*     | in  | write enable, register index, data (no handshake)
//
// A beat with no report, or closing a group with a zero period sum, is accepted, then handed off to the output reg.
// A beat completing a group with a nonzero sum also runs the dividers: the average
// divider retires one quotient bit per cycle over the 43-bit dividend, and
// then both quotients move into staging ahead of the hand-off.
// No clearing pass after reset; in_i.ready is already high as reset releases.
// A stalled output holds its beat; one new input beat is processed meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_period_meter #(
  parameter int unsigned PERIODS_PER_REPORT = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hpm_in_if.sink                        in_i,
  hpm_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [hpm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hpm_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned AVG_NUM_W = hpm_pkg::AVG_NUM_W;
  localparam int unsigned FREQ_W    = hpm_pkg::FREQ_W;
  localparam int unsigned AVG_W     = hpm_pkg::AVG_W;
  localparam int unsigned PDIV_W    = $clog2(PERIODS_PER_REPORT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_q, state_d;

  logic [hpm_pkg::THR_W-1:0]   high_thr_q;
  logic [hpm_pkg::THR_W-1:0]   low_thr_q;
  logic [hpm_pkg::SCALE_W-1:0] scale_q;

  hpm_pkg::front_t front;
  logic            accept;
  logic            div_start;
  logic            avg_busy;
  logic            freq_busy;
  logic [AVG_NUM_W-1:0] avg_quot;
  logic [FREQ_W-1:0]    freq_quot;
  logic [FREQ_W-1:0]    scale_ext;
  logic [FREQ_W-1:0]    freq_num;
  logic                 out_free;

  // Result staging
  logic              st_level_q, st_rise_q, st_rep_q, st_zero_q;
  logic [AVG_W-1:0]  st_avg_q;
  logic [FREQ_W-1:0] st_freq_q;

  // Output register
  logic              out_valid_q;
  logic              out_level_q, out_rise_q, out_rep_q, out_zero_q;
  logic [AVG_W-1:0]  out_avg_q;
  logic [FREQ_W-1:0] out_freq_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign div_start  = accept && front.report && !front.zero;
  assign out_free   = !out_valid_q || out_o.ready;

  // Frequency dividend: scale * periods with eight fraction bits
  assign scale_ext = FREQ_W'(scale_q);
  assign freq_num  = (scale_ext * FREQ_W'(PERIODS_PER_REPORT)) << hpm_pkg::FRAC_W;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= hpm_pkg::HIGH_THR_RST;
      low_thr_q  <= hpm_pkg::LOW_THR_RST;
      scale_q    <= hpm_pkg::FREQ_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hpm_pkg::REG_HIGH_THR:   high_thr_q <= cfg_data_i[hpm_pkg::THR_W-1:0];
        hpm_pkg::REG_LOW_THR:    low_thr_q  <= cfg_data_i[hpm_pkg::THR_W-1:0];
        hpm_pkg::REG_FREQ_SCALE: scale_q    <= cfg_data_i[hpm_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  hpm_front #(
    .PERIODS_PER_REPORT (PERIODS_PER_REPORT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .sample_i    (in_i.sample),
    .timestamp_i (in_i.timestamp),
    .high_thr_i  (high_thr_q),
    .low_thr_i   (low_thr_q),
    .front_o     (front)
  );

  // Average: (sum << 8) / periods
  hpm_serial_div #(
    .NUM_W (AVG_NUM_W),
    .DEN_W (PDIV_W)
  ) u_avg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({front.sum, {hpm_pkg::FRAC_W{1'b0}}}),
    .den_i   (PDIV_W'(PERIODS_PER_REPORT)),
    .busy_o  (avg_busy),
    .quot_o  (avg_quot)
  );

  // Frequency: (scale * periods << 8) / sum
  hpm_serial_div #(
    .NUM_W (FREQ_W),
    .DEN_W (hpm_pkg::SUM_W)
  ) u_freq_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (freq_num),
    .den_i   (front.sum),
    .busy_o  (freq_busy),
    .quot_o  (freq_quot)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = div_start ? ST_DIV : ST_FLUSH;
      end
      ST_DIV: begin
        if (!avg_busy && !freq_busy) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Staging of the beat under work
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_level_q <= front.level;
      st_rise_q  <= front.rise;
      st_rep_q   <= front.report;
      st_zero_q  <= front.report && front.zero;
      st_avg_q   <= '0;
      st_freq_q  <= '0;
    end else if (state_q == ST_DIV && !avg_busy && !freq_busy) begin
      st_avg_q  <= avg_quot[AVG_W-1:0];
      st_freq_q <= freq_quot;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FLUSH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FLUSH && out_free) begin
      out_level_q <= st_level_q;
      out_rise_q  <= st_rise_q;
      out_rep_q   <= st_rep_q;
      out_zero_q  <= st_zero_q;
      out_avg_q   <= st_avg_q;
      out_freq_q  <= st_freq_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.level         = out_level_q;
  assign out_o.rising_edge   = out_rise_q;
  assign out_o.report_valid  = out_rep_q;
  assign out_o.avg_period_q8 = out_avg_q;
  assign out_o.frequency_q8  = out_freq_q;
  assign out_o.zero_period   = out_zero_q;

endmodule

`default_nettype wire

### hw/rtl/hpm_serial_div.sv
// ----------------------------------------------------------------------------
// hpm_serial_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module hpm_serial_div #(
  parameter int unsigned NUM_W = 35,
  parameter int unsigned DEN_W = 35
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    part;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign busy_o = (step_q != '0);
  assign quot_o = num_q;

  // One restoring step: bring down the next dividend bit, try a subtract
  always_comb begin
    part  = {rem_q, num_q[NUM_W-1]};
    diff  = part - {1'b0, den_q};
    ge    = (part >= {1'b0, den_q});
    rem_d = ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
    num_d = {num_q[NUM_W-2:0], ge};
    step_d = step_q - STEP_W'(1);
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= STEP_W'(NUM_W);
    end else if (busy_o) begin
      step_q <= step_d;
    end
  end

  // Dividend/quotient shifter, remainder and divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_o) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hpm_front.sv
// ----------------------------------------------------------------------------
// hpm_front
// Schmitt comparator, edge timestamp and period sum accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module hpm_front #(
  parameter int unsigned PERIODS_PER_REPORT = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [hpm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [hpm_pkg::TS_W-1:0]     timestamp_i,
  input  logic [hpm_pkg::THR_W-1:0]    high_thr_i,
  input  logic [hpm_pkg::THR_W-1:0]    low_thr_i,
  output hpm_pkg::front_t              front_o
);

  localparam int unsigned CW = hpm_pkg::CNT_W;
  localparam int unsigned SW = hpm_pkg::SUM_W;

  logic                         level_q;
  logic [hpm_pkg::TS_W-1:0]     last_q;
  logic [SW-1:0]                sum_q;
  logic [CW-1:0]                cnt_q;

  logic                         set;
  logic                         clr;
  logic [hpm_pkg::TS_W-1:0]     delta;
  logic [SW-1:0]                sum_add;
  logic [CW-1:0]                cnt_inc;
  logic                         report;

  // Comparator and period arithmetic for the current beat
  always_comb begin
    set     = (sample_i > high_thr_i) && !level_q;
    clr     = (sample_i < low_thr_i) && level_q;
    delta   = timestamp_i - last_q;          // wraps modulo 2^32
    sum_add = sum_q + SW'(delta);
    cnt_inc = cnt_q + CW'(1);
    report  = set && (cnt_inc == CW'(PERIODS_PER_REPORT));

    front_o.level  = set ? 1'b1 : (clr ? 1'b0 : level_q);
    front_o.rise   = set;
    front_o.report = report;
    front_o.sum    = sum_add;
    front_o.zero   = (sum_add == '0);
  end

  // State update on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      last_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      level_q <= front_o.level;
      if (set) begin
        last_q <= timestamp_i;
        if (report) begin
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= sum_add;
          cnt_q <= cnt_inc;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hpm_checker.sv
// ----------------------------------------------------------------------------
// hpm_checker
// Port-level checks on the period meter's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hysteresis_period_meter_assert.svh"

module hpm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       level_i,
  input logic                       rising_edge_i,
  input logic                       report_valid_i,
  input logic [hpm_pkg::AVG_W-1:0]  avg_period_q8_i,
  input logic [hpm_pkg::FREQ_W-1:0] frequency_q8_i,
  input logic                       zero_period_i
);

  logic [hpm_pkg::AVG_W+hpm_pkg::FREQ_W+3:0] beat;
  logic                                      stall;
  logic                                      plain_beat;
  logic                                      rep_beat;
  logic                                      zero_beat;
  logic                                      fields_clear;

  // Whole result beat and a few beat qualifiers
  assign beat         = {level_i, rising_edge_i, report_valid_i, avg_period_q8_i,
                         frequency_q8_i, zero_period_i};
  assign stall        = out_valid_i && !out_ready_i;
  assign plain_beat   = out_valid_i && !report_valid_i;
  assign rep_beat     = out_valid_i && report_valid_i;
  assign zero_beat    = out_valid_i && zero_period_i;
  assign fields_clear = (avg_period_q8_i == '0) && (frequency_q8_i == '0);

  // Handshake: a stalled beat stays and holds
  `HPM_ASSERT_NXT(a_valid_hold, stall, out_valid_i, "result beat dropped while stalled")
  `HPM_ASSERT_NXT(a_data_hold, stall, $stable(beat), "result beat changed while stalled")

  // Report fields are clear on beats that close no group
  `HPM_ASSERT_IMP(a_no_report, plain_beat, fields_clear && !zero_period_i, "stray report fields")

  // A report only comes with a rising edge, which leaves the level high
  `HPM_ASSERT_IMP(a_report_edge, rep_beat, rising_edge_i && level_i, "report without rising edge")

  // Zero period sum forces both results to zero
  `HPM_ASSERT_IMP(a_zero_sum, zero_beat, report_valid_i && fields_clear, "nonzero zero-sum result")

endmodule

bind hysteresis_period_meter hpm_checker u_hpm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .level_i         (out_o.level),
  .rising_edge_i   (out_o.rising_edge),
  .report_valid_i  (out_o.report_valid),
  .avg_period_q8_i (out_o.avg_period_q8),
  .frequency_q8_i  (out_o.frequency_q8),
  .zero_period_i   (out_o.zero_period)
);

`default_nettype wire

### test/tb_hysteresis_period_meter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hysteresis_period_meter
// Self-checking bench for the Schmitt-trigger period meter. It first walks the
// comparator through threshold-equal samples, a zero-length period group and
// timestamp wrap. It then drives long random waveforms that swing across the
// thresholds, under several register settings and with random stalls on both
// channels. Every result beat is compared with a cycle-free prediction.
// ----------------------------------------------------------------------------
module tb_hysteresis_period_meter;

  localparam int unsigned PERIODS        = 5;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned PROBE_LEN      = 19;
  // Index past the end of the register map; writes there must be dropped
  localparam logic [hpm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                       level;
    logic                       rise;
    logic                       report;
    logic [hpm_pkg::AVG_W-1:0]  avg;
    logic [hpm_pkg::FREQ_W-1:0] freq;
    logic                       zero;
  } reading_t;

  // Tracks comparator and accumulator state and queues predicted readings
  class period_board;
    logic [hpm_pkg::THR_W-1:0]   high_thr;
    logic [hpm_pkg::THR_W-1:0]   low_thr;
    logic [hpm_pkg::SCALE_W-1:0] scale;
    logic                        level_q;
    logic [hpm_pkg::TS_W-1:0]    prev_rise_ts;
    logic [hpm_pkg::SUM_W-1:0]   sum_q;
    logic [hpm_pkg::CNT_W-1:0]   edges_q;
    reading_t                    due_readings[$];
    int                          errors;
    int                          samples;
    int                          rises;
    int                          reports;
    int                          zero_reports;

    function new();
      high_thr     = hpm_pkg::HIGH_THR_RST;
      low_thr      = hpm_pkg::LOW_THR_RST;
      scale        = hpm_pkg::FREQ_SCALE_RST;
      level_q      = 1'b0;
      prev_rise_ts = '0;
      sum_q        = '0;
      edges_q      = '0;
      errors       = 0;
      samples      = 0;
      rises        = 0;
      reports      = 0;
      zero_reports = 0;
    endfunction

    function void write_register(logic [hpm_pkg::CFG_IDX_W-1:0] idx,
                                 logic [hpm_pkg::CFG_W-1:0] data);
      case (idx)
        hpm_pkg::REG_HIGH_THR:   high_thr = data[hpm_pkg::THR_W-1:0];
        hpm_pkg::REG_LOW_THR:    low_thr  = data[hpm_pkg::THR_W-1:0];
        hpm_pkg::REG_FREQ_SCALE: scale    = data[hpm_pkg::SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one sample beat and queue the reading it must produce
    function void note_sample(logic [hpm_pkg::SAMPLE_W-1:0] s, logic [hpm_pkg::TS_W-1:0] t);
      reading_t                 r;
      logic [hpm_pkg::TS_W-1:0] delta;
      logic [63:0]              wide_sum;
      logic [63:0]              numer;
      r = '0;
      samples++;
      if (s > high_thr && !level_q) begin
        delta        = t - prev_rise_ts;
        sum_q        = sum_q + hpm_pkg::SUM_W'(delta);
        prev_rise_ts = t;
        level_q      = 1'b1;
        r.rise       = 1'b1;
        edges_q      = edges_q + hpm_pkg::CNT_W'(1);
        rises++;
      end else if (s < low_thr && level_q) begin
        level_q = 1'b0;
      end
      if (r.rise && edges_q == hpm_pkg::CNT_W'(PERIODS)) begin
        r.report = 1'b1;
        reports++;
        if (sum_q == '0) begin
          r.zero = 1'b1;
          zero_reports++;
        end else begin
          wide_sum = 64'(sum_q);
          numer    = (64'(scale) * 64'(PERIODS)) << hpm_pkg::FRAC_W;
          r.avg    = hpm_pkg::AVG_W'((wide_sum << hpm_pkg::FRAC_W) / 64'(PERIODS));
          r.freq   = hpm_pkg::FREQ_W'(numer / wide_sum);
        end
        sum_q   = '0;
        edges_q = '0;
      end
      r.level = level_q;
      due_readings.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_beat(reading_t got);
      reading_t want;
      if (due_readings.size() == 0) begin
        errors++;
        $error("result beat with no sample outstanding");
        return;
      end
      want = due_readings.pop_front();
      compare_field("level", 64'(want.level), 64'(got.level));
      compare_field("rising_edge", 64'(want.rise), 64'(got.rise));
      compare_field("report_valid", 64'(want.report), 64'(got.report));
      compare_field("avg_period_q8", 64'(want.avg), 64'(got.avg));
      compare_field("frequency_q8", 64'(want.freq), 64'(got.freq));
      compare_field("zero_period", 64'(want.zero), 64'(got.zero));
    endfunction

    function int pending();
      return due_readings.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [hpm_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [hpm_pkg::CFG_W-1:0]       cfg_data_i;

  hpm_in_if  in_ch ();
  hpm_out_if out_ch ();

  period_board board = new();

  int                       idle_pct;
  int                       stall_pct;
  bit                       calm;
  int                       stall_left;
  int                       quiet_cycles;
  int                       settings;
  logic [hpm_pkg::TS_W-1:0] stamp_now;

  // Threshold-equal samples, a full report group of rising edges at time zero, then wrapped periods
  logic [hpm_pkg::SAMPLE_W-1:0] probe_samples [PROBE_LEN] = '{
    10'd675, 10'd1023, 10'd552, 10'd0, 10'd1023, 10'd551, 10'd676, 10'd0,
    10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0,
    10'd1023, 10'd0, 10'd1023};
  logic [hpm_pkg::TS_W-1:0] probe_stamps [PROBE_LEN] = '{
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h5, 32'h7, 32'h8000_0000,
    32'h8000_0000, 32'hFFFF_FFFF};

  hysteresis_period_meter #(
    .PERIODS_PER_REPORT (PERIODS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: check each accepted beat, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      board.check_beat({out_ch.level, out_ch.rising_edge, out_ch.report_valid,
                        out_ch.avg_period_q8, out_ch.frequency_q8, out_ch.zero_period});
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 11);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One sample beat, with an optional random gap ahead of it; valid stays up
  task automatic send_sample(input logic [hpm_pkg::SAMPLE_W-1:0] s,
                             input logic [hpm_pkg::TS_W-1:0] t);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= s;
    in_ch.timestamp <= t;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    board.note_sample(s, t);
  endtask

  // Hold off the input until every queued reading has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Program all three registers plus a dropped write past the map
  task automatic program_settings(input logic [hpm_pkg::THR_W-1:0] hi,
                                  input logic [hpm_pkg::THR_W-1:0] lo,
                                  input logic [hpm_pkg::SCALE_W-1:0] sc);
    logic [hpm_pkg::CFG_IDX_W-1:0] idx [4];
    logic [hpm_pkg::CFG_W-1:0]     val [4];
    idx = '{REG_UNUSED, hpm_pkg::REG_HIGH_THR, hpm_pkg::REG_LOW_THR,
            hpm_pkg::REG_FREQ_SCALE};
    val = '{hpm_pkg::CFG_W'($urandom()), hpm_pkg::CFG_W'(hi), hpm_pkg::CFG_W'(lo), sc};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      board.write_register(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    settings++;
    case ($urandom_range(0, 2))
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 20; stall_pct = 20; end
      default: begin idle_pct = 50; stall_pct = 40; end
    endcase
  endtask

  // Mostly clean threshold crossings on an advancing timer, some noise
  task automatic run_wave(input int count);
    bit                           clean;
    int                           hi;
    int                           lo;
    logic [hpm_pkg::SAMPLE_W-1:0] s;
    logic [hpm_pkg::TS_W-1:0]     t;
    for (int i = 0; i < count; i++) begin
      clean = $urandom_range(0, 99) < 80;
      hi    = int'(board.high_thr);
      lo    = int'(board.low_thr);
      case ($urandom_range(0, 19))
        0, 1, 2: ;
        3:       stamp_now = stamp_now + $urandom();
        4, 5:    stamp_now = stamp_now + $urandom_range(0, 1 << 20);
        default: stamp_now = stamp_now + $urandom_range(1, 3000);
      endcase
      if (!clean) begin
        s = hpm_pkg::SAMPLE_W'($urandom_range(0, 1023));
      end else if (board.level_q) begin
        s = (lo == 0) ? '0 : hpm_pkg::SAMPLE_W'($urandom_range(0, lo - 1));
      end else begin
        s = (hi == 1023) ? '1 : hpm_pkg::SAMPLE_W'($urandom_range(hi + 1, 1023));
      end
      t = (clean || $urandom_range(0, 1)) ? stamp_now : $urandom();
      send_sample(s, t);
    end
  endtask

  initial begin
    int hi;
    int lo;
    in_ch.valid     = 1'b0;
    in_ch.sample    = '0;
    in_ch.timestamp = '0;
    out_ch.ready    = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = hpm_pkg::REG_HIGH_THR;
    cfg_data_i      = '0;
    rst_ni          = 1'b0;
    calm            = 1'b0;
    stall_left      = 0;
    quiet_cycles    = 0;
    settings        = 1;
    idle_pct        = 0;
    stall_pct       = 20;
    stamp_now       = $urandom();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk under reset settings
    for (int i = 0; i < PROBE_LEN; i++) send_sample(probe_samples[i], probe_stamps[i]);
    idle_pct = 30;
    run_wave(40);

    // Top threshold pinned: the level can never rise
    drain_results();
    program_settings(10'd1023, 10'd0, 24'hFF_FFFF);
    run_wave(15);

    // Low threshold above high, zero scale
    drain_results();
    program_settings(10'd0, 10'd1023, 24'd0);
    run_wave(40);

    // Random settings; the last phase runs without idling
    for (int p = 0; p < 5; p++) begin
      drain_results();
      hi = $urandom_range(1, 1022);
      lo = ($urandom_range(0, 4) == 0) ? $urandom_range(hi, 1023) : $urandom_range(0, hi);
      program_settings(hpm_pkg::THR_W'(hi), hpm_pkg::THR_W'(lo),
                       (p == 0) ? 24'd1 : hpm_pkg::SCALE_W'($urandom_range(1, 24'hFF_FFFF)));
      if (p == 4) calm = 1'b1;
      run_wave(60);
    end

    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.pending() != 0) begin
      board.errors++;
      $error("%0d readings never arrived", board.pending());
    end

    $display("Covered %0d samples, %0d rising edges, %0d reports (%0d with zero sum)",
             board.samples, board.rises, board.reports, board.zero_reports);
    $display("over %0d register settings, with timer wrap and stalls on both channels",
             settings);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
